// ===== hw/rtl/swts_pkg.sv =====
// shared types, constants and arithmetic helpers for the string wave stepper
package swts_pkg;

  localparam int unsigned DefaultMaxPoints = 64;
  localparam int unsigned WordW            = 32;
  localparam int unsigned IdxW             = 6;
  localparam int unsigned CountW           = 7;
  localparam int unsigned MinPoints        = 4;
  localparam logic [WordW-1:0] DefaultTimeStep = 32'd1677722;

  typedef enum logic [1:0] {
    ActLoad = 2'd0,
    ActStep = 2'd1,
    ActRead = 2'd2,
    ActNone = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegActivePoints = 2'd0,
    RegBoundaryMode = 2'd1,
    RegTimeStep     = 2'd2,
    RegUnused       = 2'd3
  } reg_index_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StSweep = 2'd1,
    StWrite = 2'd2
  } state_e;

  // one point of the string as it moves down the chain
  typedef struct packed {
    logic [WordW-1:0] pos;
    logic [WordW-1:0] vel;
    logic [WordW-1:0] stiff;
    logic [WordW-1:0] damp;
  } point_t;

  // control for a cell; every cell but the tail shares one copy
  typedef struct packed {
    logic shift;     // rotate the ring by one place
    logic load;      // write the tail cell from the load beat
  } cell_ctrl_t;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic [WordW-1:0] sat34(input logic signed [33:0] x, output logic clip);
    logic [WordW-1:0] r;
    clip = 1'b0;
    r    = x[WordW-1:0];
    if (x > 34'sh0_7FFF_FFFF) begin
      clip = 1'b1;
      r    = 32'h7FFF_FFFF;
    end else if (x < -34'sh0_8000_0000) begin
      clip = 1'b1;
      r    = 32'h8000_0000;
    end
    return r;
  endfunction

  // signed 32 times unsigned q8.24, rounded half up back to the scale of a (41 bits signed)
  function automatic logic signed [40:0] mul_q24(input logic signed [WordW-1:0] a,
                                                 input logic [WordW-1:0] c);
    logic signed [64:0] prod;
    prod = a * $signed({1'b0, c});
    prod = prod + 65'sd8388608;
    return prod[64:24];
  endfunction

endpackage

// ===== hw/rtl/swts_cell.sv =====
// one storage cell of the point ring, shifts to its neighbor whenever the ring rotates
module swts_cell (
  input  logic                 clk_i,
  input  swts_pkg::cell_ctrl_t ctrl_i,
  input  swts_pkg::point_t     prev_i,
  input  swts_pkg::point_t     load_i,
  output swts_pkg::point_t     pt_o
);
  import swts_pkg::*;

  point_t pt_q, pt_d;

  always_comb begin
    pt_d = pt_q;
    if (ctrl_i.load) pt_d = load_i;
    else if (ctrl_i.shift) pt_d = prev_i;
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o = pt_q;
endmodule

// ===== hw/rtl/swts_update.sv =====
// point update datapath: laplacian or end difference, velocity, then position
module swts_update (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  swts_pkg::point_t        cur_i,
  input  logic [31:0]             left_pos_i,
  input  logic [31:0]             right_pos_i,
  input  logic                    is_first_i,
  input  logic                    is_last_i,
  input  logic                    free_i,
  input  logic [31:0]             dt_i,
  output swts_pkg::point_t        pt_o,
  output logic                    clip_o
);
  import swts_pkg::*;

  // stage 1: difference and products with k and d
  logic signed [33:0] diff_s;
  logic [WordW-1:0]   diff_w;
  logic               c0, c1, c2;
  logic signed [40:0] kprod, dprod;
  logic signed [41:0] vsum;
  logic               is_end;
  logic [WordW-1:0]   v_new, p_new;
  logic signed [40:0] vprod_q, vprod_d;
  point_t             p1_q, p1_d;
  logic               c_q, c_d, end_q, end_d, free_q;
  logic signed [40:0] tprod;
  logic signed [41:0] psum;

  assign is_end = is_first_i | is_last_i;

  always_comb begin
    if (is_first_i)
      diff_s = $signed({{2{right_pos_i[31]}}, right_pos_i}) -
               $signed({{2{cur_i.pos[31]}}, cur_i.pos});
    else if (is_last_i)
      diff_s = $signed({{2{left_pos_i[31]}}, left_pos_i}) -
               $signed({{2{cur_i.pos[31]}}, cur_i.pos});
    else
      diff_s = $signed({{2{left_pos_i[31]}}, left_pos_i}) -
               2 * $signed({{2{cur_i.pos[31]}}, cur_i.pos}) +
               $signed({{2{right_pos_i[31]}}, right_pos_i});
    diff_w = sat34(diff_s, c0);
    kprod  = mul_q24($signed(diff_w), cur_i.stiff);
    dprod  = (is_end) ? mul_q24($signed(cur_i.vel), cur_i.damp) : 41'sd0;
    vprod_d = kprod - dprod;
    p1_d   = cur_i;
    end_d  = is_end;
    c_d    = c0 & ~(is_end & ~free_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vprod_q <= vprod_d;
      p1_q    <= p1_d;
      c_q     <= c_d;
      end_q   <= end_d;
      free_q  <= free_i;
    end
  end

  // stage 2: new velocity then position (second multiply after register on v)
  always_comb begin
    vsum  = $signed({{10{p1_q.vel[31]}}, p1_q.vel}) + vprod_q;
    v_new = sat34(vsum[33:0], c1);
    if (vsum > 42'sh7FFF_FFFF || vsum < -42'sh8000_0000) begin
      c1 = 1'b1;
      v_new = vsum[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    tprod = mul_q24($signed(v_new), dt_i);
    psum  = $signed({{10{p1_q.pos[31]}}, p1_q.pos}) + tprod;
    p_new = sat34(psum[33:0], c2);
    if (psum > 42'sh7FFF_FFFF || psum < -42'sh8000_0000) begin
      c2 = 1'b1;
      p_new = psum[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    pt_o = p1_q;
    if (end_q & ~free_q) begin
      clip_o = 1'b0;
    end else begin
      pt_o.vel = v_new;
      pt_o.pos = p_new;
      clip_o   = c_q | c1 | c2;
    end
  end
endmodule

// ===== hw/rtl/string_wave_time_step.sv =====
// top level of the string wave stepper: ring of point cells and one update unit
// A load or read keeps busy high while the ring makes one full lap, and a
// step while every point passes the update unit: the points sit in a ring of
// cells that rotates once per cycle while busy, so an access waits for the
// addressed point to reach the head cell and a step passes every point through
// the one update unit on its way round. The result beat shows in the first
// cycle with busy low, so a new beat may start in that same cycle. An unused
// action answers in the next cycle without going busy. Start a beat only while
// busy is low; exactly one result beat follows each item, marked by done_o for a
// single cycle, and it cannot be held off, so the receiver must take it then. No
// clearing pass runs after reset.
module string_wave_time_step #(
  parameter int unsigned MAX_POINTS = swts_pkg::DefaultMaxPoints
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [5:0]         point_index_i,
  input  logic signed [31:0] load_position_i,
  input  logic signed [31:0] load_velocity_i,
  input  logic [31:0]        stiffness_coef_i,
  input  logic [31:0]        end_damping_coef_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic [5:0]         result_index_o,
  output logic signed [31:0] result_position_o,
  output logic signed [31:0] result_velocity_o,
  output logic               saturated_o
);
  import swts_pkg::*;

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned CW = PW + 2;

  // configuration registers
  logic [CountW-1:0] act_q;
  logic              mode_q;
  logic [WordW-1:0]  dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= CountW'(64);
      mode_q <= 1'b1;
      dt_q   <= DefaultTimeStep;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        RegActivePoints: act_q  <= cfg_data_i[CountW-1:0];
        RegBoundaryMode: mode_q <= cfg_data_i[0];
        RegTimeStep:     dt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective point count
  logic [CW-1:0] n_eff;
  always_comb begin
    if (32'(act_q) < MinPoints) n_eff = CW'(MinPoints);
    else if (32'(act_q) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
    else n_eff = CW'(act_q);
  end

  // ring of cells; cell 0 is the head; rotation: cell i takes cell i+1
  point_t     cells [MAX_POINTS];
  point_t     head_in;
  cell_ctrl_t ctrl, tail_ctrl;
  point_t     load_d, load_q;

  assign load_d = '{pos: load_position_i, vel: load_velocity_i,
                    stiff: stiffness_coef_i, damp: end_damping_coef_i};

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    if (g == MAX_POINTS - 1) begin : g_tail
      swts_cell u_cell (.clk_i, .ctrl_i(tail_ctrl), .prev_i(head_in),
                        .load_i(load_q), .pt_o(cells[g]));
    end else if (g == 0) begin : g_head
      swts_cell u_cell (.clk_i, .ctrl_i(ctrl), .prev_i(cells[g+1]),
                        .load_i(load_q), .pt_o(cells[g]));
    end else begin : g_mid
      swts_cell u_cell (.clk_i, .ctrl_i(ctrl), .prev_i(cells[g+1]),
                        .load_i(load_q), .pt_o(cells[g]));
    end
  end

  // state
  state_e          st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;      // rotations done
  logic [1:0]      act_sv_q;
  logic [IdxW-1:0] idx_q;
  logic            clip_q, clip_d;    // running clip during a step
  logic            sat_q, sat_d;
  logic [WordW-1:0] prev_pos_q;       // old position of previous point
  logic            in_range;
  logic            at_idx;
  logic            done_d;
  logic            acc;

  assign acc      = start & ~busy;
  assign busy     = (st_q != StIdle);
  assign in_range = (32'(idx_q) < MAX_POINTS);
  assign at_idx   = (st_q == StWrite) && (32'(cnt_q) == 32'(idx_q));

  // step timing: the ring shifts on every sweep cycle. In sweep cycle r point
  // r sits in cell 0 and point r+1 in cell 1, and the old position of point
  // r-1 is held in prev_pos_q. The update unit has one register, so the new
  // value of point r enters the tail in the cycle after. The value that enters
  // the tail in the first cycle is a filler that leaves the head on the last
  // cycle, so the ring ends with point 0 at the head again.

  logic            upd_en;
  point_t          upd_out;
  logic            upd_clip;
  logic            is_first, is_last, active_pt;
  logic            vld_q;             // update pipe valid
  logic            pass_q;            // point bypasses update (inactive)
  logic [CW-1:0]   fed_q, fed_d;      // points fed into the pipe

  assign is_first  = (fed_q == '0);
  assign is_last   = (fed_q == n_eff - CW'(1));
  assign active_pt = (fed_q < n_eff);

  swts_update u_update (
    .clk_i, .en_i(upd_en), .cur_i(cells[0]),
    .left_pos_i(prev_pos_q), .right_pos_i(cells[1].pos),
    .is_first_i(is_first), .is_last_i(is_last), .free_i(mode_q),
    .dt_i(dt_q), .pt_o(upd_out), .clip_o(upd_clip)
  );

  // old value of the point fed in the previous cycle, for points past the count
  point_t hold_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    fed_d   = fed_q;
    clip_d  = clip_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    ctrl    = '0;
    upd_en  = 1'b0;
    head_in = cells[0];
    unique case (st_q)
      StIdle: begin
        if (acc && action_e'(action_i) == ActStep) begin
          st_d   = StSweep;
          fed_d  = '0;
          clip_d = 1'b0;
        end else if (acc && action_e'(action_i) == ActNone) begin
          done_d = 1'b1;
        end else if (acc) begin
          st_d  = StWrite;
          cnt_d = '0;
        end
      end
      StSweep: begin
        upd_en = 1'b1;
        ctrl.shift = 1'b1;
        // tail receives the result of the point fed in the previous cycle
        head_in = pass_q ? hold_q : upd_out;
        fed_d = fed_q + CW'(1);
        if (vld_q && !pass_q) clip_d = clip_q | upd_clip;
        if (fed_q == CW'(MAX_POINTS)) begin
          st_d   = StIdle;
          sat_d  = clip_d;
          done_d = 1'b1;
        end
      end
      StWrite: begin
        // one full lap; the addressed point passes the head on the way
        ctrl.shift = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_POINTS) - CW'(1)) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // a load replaces the addressed point as it moves from the head to the tail
  always_comb begin
    tail_ctrl = ctrl;
    if (at_idx && act_sv_q == 2'(ActLoad)) begin
      tail_ctrl.load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      cnt_q    <= '0;
      fed_q    <= '0;
      clip_q   <= 1'b0;
      sat_q    <= 1'b0;
      vld_q    <= 1'b0;
      pass_q   <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      fed_q    <= fed_d;
      clip_q   <= clip_d;
      sat_q    <= sat_d;
      vld_q    <= (st_q == StSweep);
      pass_q   <= !active_pt;
      done_o   <= done_d | (st_q == StWrite && cnt_q == CW'(MAX_POINTS) - CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      act_sv_q <= action_i;
      idx_q    <= point_index_i;
      load_q   <= load_d;
    end
    hold_q <= cells[0];
    if (st_q == StSweep) prev_pos_q <= cells[0].pos;
  end

  // result capture: the ring rests with point 0 at the head, so the addressed
  // point reaches the head after idx rotations
  logic [WordW-1:0] rpos_q, rvel_q;
  always_ff @(posedge clk_i) begin
    if (at_idx) begin
      if (act_sv_q == 2'(ActLoad)) begin
        rpos_q <= load_q.pos;
        rvel_q <= load_q.vel;
      end else begin
        rpos_q <= cells[0].pos;
        rvel_q <= cells[0].vel;
      end
    end
  end

  always_comb begin
    result_index_o    = '0;
    result_position_o = '0;
    result_velocity_o = '0;
    if (act_sv_q == 2'(ActLoad) || act_sv_q == 2'(ActRead)) begin
      result_index_o = idx_q;
      if (in_range) begin
        result_position_o = rpos_q;
        result_velocity_o = rvel_q;
      end
    end
    if (act_sv_q == 2'(ActStep) || act_sv_q == 2'(ActNone)) begin
      result_index_o = '0;
    end
    saturated_o = sat_q;
  end

`ifndef SYNTHESIS
  // a result beat only leaves the block when it goes back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q) != StSweep || st_q == StIdle)
    else $error("result beat while busy");
  // a sweep only continues or returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSweep) |=> (st_q == StSweep || st_q == StIdle))
    else $error("sweep left to wrong state");
  // the step flag moves only at the end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StWrite) |=> $stable(sat_q))
    else $error("flag changed by load or read");
`endif
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the string wave stepper
`timescale 1ns / 1ps

module testbench;
  import swts_pkg::*;

  // one command beat as the driver puts it on the ports
  typedef struct {
    action_e     act;
    logic [5:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] stiff;
    logic [31:0] damp;
  } beat_t;

  // one result beat as the block reports it
  typedef struct {
    logic [5:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        sat;
  } point_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = 2'd0;
  logic [5:0]  point_index_i = 6'd0;
  logic [31:0] load_position_i = 32'd0;
  logic [31:0] load_velocity_i = 32'd0;
  logic [31:0] stiffness_coef_i = 32'd0;
  logic [31:0] end_damping_coef_i = 32'd0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [31:0] cfg_data_i = 32'd0;
  logic        done_o;
  logic [5:0]  result_index_o;
  logic [31:0] result_position_o;
  logic [31:0] result_velocity_o;
  logic        saturated_o;

  string_wave_time_step dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .point_index_i, .load_position_i,
    .load_velocity_i, .stiffness_coef_i, .end_damping_coef_i, .cfg_we_i,
    .cfg_index_i, .cfg_data_i, .done_o, .result_index_o, .result_position_o,
    .result_velocity_o, .saturated_o
  );

  always #5 clk_i = ~clk_i;

  // string state mirrored by the predictor
  logic [31:0] str_pos [64];
  logic [31:0] str_vel [64];
  logic [31:0] str_stiff [64];
  logic [31:0] str_damp [64];
  bit          last_step_clipped = 1'b0;
  logic [6:0]  cfg_points = 7'd64;
  logic        cfg_free_ends = 1'b1;
  logic [31:0] cfg_dt = DefaultTimeStep;

  beat_t         pending_beats[$];
  point_report_t expected_reports[$];
  int            mismatches = 0;
  bit            hold_sender = 1'b0;

  function automatic longint sx(logic [31:0] u);
    return longint'($signed(u));
  endfunction

  // clip to 32 bits signed, noting any clip
  function automatic logic [31:0] clamp32(longint x, inout bit clipped);
    if (x > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (x < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  // signed value times unsigned q8.24 coefficient, rounded half up
  function automatic longint rnd_mul(longint a, logic [31:0] c);
    longint p;
    p = a * longint'(c);
    return (p + 64'sd8388608) >>> 24;
  endfunction

  function automatic void advance_string();
    logic [31:0] nxt_pos [64];
    logic [31:0] nxt_vel [64];
    int          n;
    int          e;
    int          nb;
    bit          clipped;
    longint      p;
    longint      v;
    logic [31:0] lap;
    logic [31:0] vb;
    clipped = 1'b0;
    n = (cfg_points < 4) ? 4 : ((cfg_points > 64) ? 64 : int'(cfg_points));
    for (int i = 1; i + 1 < n; i++) begin
      p   = sx(str_pos[i]);
      lap = clamp32(sx(str_pos[i-1]) - 2 * p + sx(str_pos[i+1]), clipped);
      vb  = clamp32(sx(str_vel[i]) + rnd_mul(sx(lap), str_stiff[i]), clipped);
      nxt_vel[i] = vb;
      nxt_pos[i] = clamp32(p + rnd_mul(sx(vb), cfg_dt), clipped);
    end
    for (int k = 0; k < 2; k++) begin
      e  = (k == 0) ? 0 : n - 1;
      nb = (k == 0) ? 1 : n - 2;
      if (cfg_free_ends) begin
        // one-sided difference toward the neighbor, minus end damping
        p   = sx(str_pos[e]);
        v   = sx(str_vel[e]);
        lap = clamp32(sx(str_pos[nb]) - p, clipped);
        vb  = clamp32(v + rnd_mul(sx(lap), str_stiff[e]) - rnd_mul(v, str_damp[e]), clipped);
        nxt_vel[e] = vb;
        nxt_pos[e] = clamp32(p + rnd_mul(sx(vb), cfg_dt), clipped);
      end else begin
        nxt_pos[e] = str_pos[e];
        nxt_vel[e] = str_vel[e];
      end
    end
    for (int i = 0; i < n; i++) begin
      str_pos[i] = nxt_pos[i];
      str_vel[i] = nxt_vel[i];
    end
    last_step_clipped = clipped;
  endfunction

  function automatic point_report_t apply_beat(beat_t b);
    point_report_t r;
    r = '{idx: 6'd0, pos: 32'd0, vel: 32'd0, sat: 1'b0};
    case (b.act)
      ActLoad, ActRead: begin
        if (b.act == ActLoad) begin
          str_pos[b.idx]   = b.pos;
          str_vel[b.idx]   = b.vel;
          str_stiff[b.idx] = b.stiff;
          str_damp[b.idx]  = b.damp;
        end
        r.idx = b.idx;
        r.pos = str_pos[b.idx];
        r.vel = str_vel[b.idx];
      end
      ActStep: advance_string();
      default: ;
    endcase
    r.sat = last_step_clipped;
    return r;
  endfunction

  // driver: bursts of beats separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    beat_t b;
    if (start && !busy) begin
      b.act   = action_e'(action_i);
      b.idx   = point_index_i;
      b.pos   = load_position_i;
      b.vel   = load_velocity_i;
      b.stiff = stiffness_coef_i;
      b.damp  = end_damping_coef_i;
      expected_reports.push_back(apply_beat(b));
    end
    if (!(start && busy)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_beats.size() > 0 && !hold_sender) begin
        b = pending_beats.pop_front();
        action_i           <= b.act;
        point_index_i      <= b.idx;
        load_position_i    <= b.pos;
        load_velocity_i    <= b.vel;
        stiffness_coef_i   <= b.stiff;
        end_damping_coef_i <= b.damp;
        start <= 1'b1;
        if (burst_left <= 1) begin
          // end of burst; a zero gap keeps some stretches back to back
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done_o beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    point_report_t w;
    if (done_o) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat idx %0d", result_index_o);
      end else begin
        w = expected_reports.pop_front();
        if (w.idx !== result_index_o || w.pos !== result_position_o ||
            w.vel !== result_velocity_o || w.sat !== saturated_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d pos %h vel %h sat %b, got %0d %h %h %b",
                     w.idx, w.pos, w.vel, w.sat, result_index_o, result_position_o,
                     result_velocity_o, saturated_o);
        end
      end
    end
  end

  // data word: mostly small signed, sometimes extreme or full range
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $signed($urandom) >>> $urandom_range(4, 14);
    endcase
  endfunction

  // coefficient: mostly at most one, sometimes anything
  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom_range(0, 32'h0100_0000) >> $urandom_range(0, 6);
    endcase
  endfunction

  function automatic beat_t make_beat(action_e a, logic [5:0] i);
    beat_t b;
    b.act   = a;
    b.idx   = i;
    b.pos   = pick_word();
    b.vel   = pick_word();
    b.stiff = pick_coef();
    b.damp  = pick_coef();
    return b;
  endfunction

  task automatic wait_idle();
    wait (pending_beats.size() == 0 && expected_reports.size() == 0 && !start && !busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e r, logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    case (r)
      RegActivePoints: cfg_points = d[6:0];
      RegBoundaryMode: cfg_free_ends = d[0];
      RegTimeStep:     cfg_dt = d;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    beat_t b;
    int    r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every point loaded first so no step or read sees an unwritten entry
    for (int i = 0; i < 64; i++) pending_beats.push_back(make_beat(ActLoad, 6'(i)));
    // extremes at both ends
    b = make_beat(ActLoad, 6'd0);
    b.pos = 32'h7FFF_FFFF; b.vel = 32'h8000_0000; b.stiff = 32'hFFFF_FFFF; b.damp = 32'h0;
    pending_beats.push_back(b);
    b = make_beat(ActLoad, 6'd63);
    b.pos = 32'h8000_0000; b.vel = 32'h7FFF_FFFF; b.stiff = 32'h0; b.damp = 32'hFFFF_FFFF;
    pending_beats.push_back(b);
    pending_beats.push_back(make_beat(ActStep, 6'd0));   // clipping step
    pending_beats.push_back(make_beat(ActRead, 6'd0));
    pending_beats.push_back(make_beat(ActRead, 6'd63));
    pending_beats.push_back(make_beat(ActNone, 6'd21));  // unused action
    pending_beats.push_back(make_beat(ActLoad, 6'd0));
    pending_beats.push_back(make_beat(ActLoad, 6'd63));
    pending_beats.push_back(make_beat(ActStep, 6'd5));
    pending_beats.push_back(make_beat(ActRead, 6'd1));

    // part way through, pause the sender until every result is back
    wait (pending_beats.size() < 40);
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    wait (expected_reports.size() == 0 && !start && !busy);
    hold_sender = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        1: begin
          write_reg(RegActivePoints, 32'd4);
          write_reg(RegBoundaryMode, 32'd0);
        end
        2: begin
          write_reg(RegActivePoints, 32'hFFFF_FFFF);  // 127 acts as the full string
          write_reg(RegTimeStep, 32'hFFFF_FFFF);
          write_reg(RegBoundaryMode, 32'd1);
        end
        3: begin
          write_reg(RegActivePoints, 32'd0);          // below the minimum
          write_reg(RegTimeStep, 32'd0);
        end
        4: begin
          write_reg(RegActivePoints, $urandom_range(5, 63));
          write_reg(RegBoundaryMode, 32'd0);
          write_reg(RegTimeStep, $urandom_range(0, 32'h0100_0000));
        end
        5: begin
          write_reg(RegActivePoints, 32'd64);
          write_reg(RegTimeStep, $urandom);
        end
        6: begin
          write_reg(RegActivePoints, $urandom_range(4, 64));
          write_reg(RegBoundaryMode, 32'd1);
          write_reg(RegTimeStep, DefaultTimeStep);
        end
        7: begin
          write_reg(RegActivePoints, 32'd64);
          write_reg(RegBoundaryMode, 32'd1);
          write_reg(RegTimeStep, 32'h0080_0000);
        end
        default: ;
      endcase
      for (int k = 0; k < 130; k++) begin
        r = $urandom_range(0, 19);
        if (r < 6) pending_beats.push_back(make_beat(ActLoad, 6'($urandom_range(0, 63))));
        else if (r < 13) pending_beats.push_back(make_beat(ActStep, 6'($urandom_range(0, 63))));
        else if (r < 19) pending_beats.push_back(make_beat(ActRead, 6'($urandom_range(0, 63))));
        else pending_beats.push_back(make_beat(ActNone, 6'($urandom_range(0, 63))));
      end
    end

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // overall timeout
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swts_pkg.sv
hw/rtl/swts_cell.sv
hw/rtl/swts_update.sv
hw/rtl/string_wave_time_step.sv
tb/testbench.sv
